[rtl/core/vst_pkg.sv]
package vst_pkg;

  localparam int CW     = 16;
  localparam int FRAC   = CW - 4;
  localparam int PW     = 2 * CW;
  localparam int MW     = CW + 1;
  localparam int REM_W  = MW + CW;
  localparam int NREGS  = 7;
  localparam int AW     = 5;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_SCALE_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_FOCAL    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    coord_t scale_x;
    coord_t scale_y;
    coord_t scale_z;
    coord_t offset_x;
    coord_t offset_y;
    coord_t offset_z;
    coord_t focal;
  } vst_cfg_t;

  typedef struct packed {
    logic             vld;
    logic             fault;
    logic             neg_x;
    logic             neg_y;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [MW-1:0]    m;
    logic [CW-1:0]    q_x;
    logic [CW-1:0]    q_y;
  } div_req_t;

  localparam coord_t CMAX = coord_t'({1'b0, {(CW-1){1'b1}}});
  localparam coord_t CMIN = coord_t'({1'b1, {(CW-1){1'b0}}});

  function automatic coord_t sat_coord(input logic signed [PW:0] v);
    if (v > (PW+1)'(signed'(CMAX))) begin
      return CMAX;
    end else if (v < (PW+1)'(signed'(CMIN))) begin
      return CMIN;
    end
    return v[CW-1:0];
  endfunction

endpackage

[rtl/core/vertex_scale_translate_project_top.sv]
// Perspective vertex transform: each vertex (Q4.12) is scaled and offset per
// axis, then projected as focal_length * coord / (z' + 1), rounded to nearest
// and saturated. A request is taken every cycle (busy stays low). Its result
// appears with done high after four register stages of multiply, offset and
// setup (the first loads at the edge that takes the request), then a chain
// of 16 divider cells that each settle one quotient bit, then the output
// register. The receiver cannot stall, so done is a one-cycle strobe.
// div_fault marks z' + 1 equal to zero, with both projections zero. The user
// must write registers over the APB port only while no request is in flight;
// the block itself does not enforce it.
module vertex_scale_translate_project_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  vst_pkg::coord_t        in_x,
  input  vst_pkg::coord_t        in_y,
  input  vst_pkg::coord_t        in_z,
  output logic                   done,
  output vst_pkg::coord_t        proj_x,
  output vst_pkg::coord_t        proj_y,
  output logic                   div_fault,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [vst_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import vst_pkg::*;

  vst_cfg_t cfg;
  div_req_t chain [CW+1];
  reg_idx_t widx;
  logic     wr;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[AW-1:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x  <= coord_t'(1 <<< FRAC);
      cfg.scale_y  <= coord_t'(1 <<< FRAC);
      cfg.scale_z  <= coord_t'(1 <<< FRAC);
      cfg.offset_x <= '0;
      cfg.offset_y <= '0;
      cfg.offset_z <= '0;
      cfg.focal    <= coord_t'(1 <<< FRAC);
    end else if (wr) begin
      unique case (widx)
        REG_SCALE_X:  cfg.scale_x  <= pwdata[CW-1:0];
        REG_SCALE_Y:  cfg.scale_y  <= pwdata[CW-1:0];
        REG_SCALE_Z:  cfg.scale_z  <= pwdata[CW-1:0];
        REG_OFFSET_X: cfg.offset_x <= pwdata[CW-1:0];
        REG_OFFSET_Y: cfg.offset_y <= pwdata[CW-1:0];
        REG_OFFSET_Z: cfg.offset_z <= pwdata[CW-1:0];
        REG_FOCAL:    cfg.focal    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SCALE_X:  prdata = 32'(cfg.scale_x);
      REG_SCALE_Y:  prdata = 32'(cfg.scale_y);
      REG_SCALE_Z:  prdata = 32'(cfg.scale_z);
      REG_OFFSET_X: prdata = 32'(cfg.offset_x);
      REG_OFFSET_Y: prdata = 32'(cfg.offset_y);
      REG_OFFSET_Z: prdata = 32'(cfg.offset_z);
      REG_FOCAL:    prdata = 32'(cfg.focal);
      default:      prdata = '0;
    endcase
  end

  vst_front u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .in_x (in_x),
    .in_y (in_y),
    .in_z (in_z),
    .cfg  (cfg),
    .req  (chain[0])
  );

  for (genvar i = 0; i < CW; i++) begin : g_cell
    vst_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  div_req_t last;
  coord_t   rx, ry;
  assign last = chain[CW];

  // top quotient bit set means the magnitude is out of range
  always_comb begin
    if (last.fault) begin
      rx = '0;
    end else if (last.q_x[CW-1]) begin
      rx = last.neg_x ? CMIN : CMAX;
    end else begin
      rx = last.neg_x ? coord_t'(-last.q_x) : coord_t'(last.q_x);
    end
    if (last.fault) begin
      ry = '0;
    end else if (last.q_y[CW-1]) begin
      ry = last.neg_y ? CMIN : CMAX;
    end else begin
      ry = last.neg_y ? coord_t'(-last.q_y) : coord_t'(last.q_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.vld;
    end
    proj_x    <= rx;
    proj_y    <= ry;
    div_fault <= last.fault;
  end

endmodule

[rtl/core/vst_front.sv]
module vst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vst_pkg::coord_t   in_x,
  input  vst_pkg::coord_t   in_y,
  input  vst_pkg::coord_t   in_z,
  input  vst_pkg::vst_cfg_t cfg,
  output vst_pkg::div_req_t req
);
  import vst_pkg::*;

  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC - 1);
  localparam logic signed [MW:0]   ONE  = (MW+1)'(1) <<< FRAC;

  // stage a: scale products
  logic                 va;
  logic signed [PW-1:0] px, py, pz;
  // stage b: scaled and offset coordinates
  logic                 vb;
  coord_t               xs, ys, zs;
  // stage c: numerators and divisor
  logic                 vc;
  logic signed [PW-1:0] nx, ny;
  logic signed [MW:0]   dz;

  logic signed [PW-1:0] rx, ry, rz;
  logic [PW-1:0]        ax, ay;
  logic [MW:0]          ad;
  logic [MW-1:0]        m_next;

  always_comb begin
    rx = (px + HALF) >>> FRAC;
    ry = (py + HALF) >>> FRAC;
    rz = (pz + HALF) >>> FRAC;
    ax = nx[PW-1] ? PW'(-nx) : PW'(nx);
    ay = ny[PW-1] ? PW'(-ny) : PW'(ny);
    ad = dz[MW] ? (MW+1)'(-dz) : (MW+1)'(dz);
    m_next = ad[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      req.vld <= 1'b0;
    end else begin
      va <= start;
      vb <= va;
      vc <= vb;
      req.vld <= vc;
    end
    px <= PW'(in_x) * PW'(cfg.scale_x);
    py <= PW'(in_y) * PW'(cfg.scale_y);
    pz <= PW'(in_z) * PW'(cfg.scale_z);
    xs <= sat_coord((PW+1)'(rx) + (PW+1)'(cfg.offset_x));
    ys <= sat_coord((PW+1)'(ry) + (PW+1)'(cfg.offset_y));
    zs <= sat_coord((PW+1)'(rz) + (PW+1)'(cfg.offset_z));
    nx <= PW'(xs) * PW'(cfg.focal);
    ny <= PW'(ys) * PW'(cfg.focal);
    dz <= (MW+1)'(zs) + ONE;
    // rounding to nearest: add half the divisor to the magnitude
    req.fault <= (dz == '0);
    req.neg_x <= nx[PW-1] ^ dz[MW];
    req.neg_y <= ny[PW-1] ^ dz[MW];
    req.m     <= m_next;
    req.rem_x <= REM_W'(ax) + REM_W'(m_next >> 1);
    req.rem_y <= REM_W'(ay) + REM_W'(m_next >> 1);
    req.q_x   <= '0;
    req.q_y   <= '0;
  end

endmodule

[rtl/core/vst_div_cell.sv]
module vst_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  vst_pkg::div_req_t din,
  output vst_pkg::div_req_t dout
);
  import vst_pkg::*;

  logic [REM_W-1:0] dv;
  logic             bx, by;
  logic [REM_W-1:0] sx, sy;

  // divisor aligned to the top quotient bit; the remainder shifts past it
  always_comb begin
    dv = REM_W'({din.m, {(CW-1){1'b0}}});
    bx = din.rem_x >= dv;
    by = din.rem_y >= dv;
    sx = bx ? din.rem_x - dv : din.rem_x;
    sy = by ? din.rem_y - dv : din.rem_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.fault <= din.fault;
    dout.neg_x <= din.neg_x;
    dout.neg_y <= din.neg_y;
    dout.m     <= din.m;
    dout.rem_x <= sx << 1;
    dout.rem_y <= sy << 1;
    dout.q_x   <= {din.q_x[CW-2:0], bx};
    dout.q_y   <= {din.q_y[CW-2:0], by};
  end

endmodule

[verif/vertex_scale_translate_project_top_tb.sv]
`timescale 1ns / 1ps

module vertex_scale_translate_project_top_tb;
  import vst_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   fault;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t in_x = '0, in_y = '0, in_z = '0;
  logic done;
  coord_t proj_x, proj_y;
  logic div_fault;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vertex_t pending_q[$];
  proj_t   proj_q[$];
  int      errors = 0;
  int      idle_pct = 0;

  // shadow copy of the registers
  longint sc_x, sc_y, sc_z, of_x, of_y, of_z, focal;

  vertex_scale_translate_project_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // product rounded half up, i.e. floor((c*s + half) / 2^12)
  function automatic longint scale_shift(longint c, longint s, longint o);
    longint p;
    p = (c * s + 2048) >>> 12;
    return clamp(p + o);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint n, m, q;
    n = num < 0 ? -num : num;
    m = den < 0 ? -den : den;
    q = (n + m / 2) / m;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic proj_t project(vertex_t v);
    proj_t r;
    longint x, y, z, d;
    x = scale_shift(longint'(v.x), sc_x, of_x);
    y = scale_shift(longint'(v.y), sc_y, of_y);
    z = scale_shift(longint'(v.z), sc_z, of_z);
    d = z + 4096;
    if (d == 0) begin
      r.px = '0;
      r.py = '0;
      r.fault = 1'b1;
    end else begin
      r.px = coord_t'(clamp(round_div(x * focal, d)));
      r.py = coord_t'(clamp(round_div(y * focal, d)));
      r.fault = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver: requests leave the queue one per accepted cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        proj_q.push_back(project('{in_x, in_y, in_z}));
        void'(pending_q.pop_front());
      end
      if (start && busy) begin
        // hold the request
      end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_x <= pending_q[0].x;
        in_y <= pending_q[0].y;
        in_z <= pending_q[0].z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    proj_t want;
    if (!rst && done) begin
      if (proj_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = proj_q.pop_front();
        if (proj_x !== want.px) report_mismatch("proj_x", proj_x, want.px);
        if (proj_y !== want.py) report_mismatch("proj_y", proj_y, want.py);
        if (div_fault !== want.fault) report_mismatch("div_fault", div_fault, want.fault);
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, coord_t val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'(4 * int'(idx));
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCALE_X:  sc_x = longint'(val);
      REG_SCALE_Y:  sc_y = longint'(val);
      REG_SCALE_Z:  sc_z = longint'(val);
      REG_OFFSET_X: of_x = longint'(val);
      REG_OFFSET_Y: of_y = longint'(val);
      REG_OFFSET_Z: of_z = longint'(val);
      default:      focal = longint'(val);
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start && proj_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0: return CMAX;
      1: return CMIN;
      2: return coord_t'($urandom_range(8191) - 4096);
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic push_vertex(coord_t x, coord_t y, coord_t z);
    pending_q.push_back('{x, y, z});
  endtask

  initial begin
    coord_t zf;
    sc_x = 4096; sc_y = 4096; sc_z = 4096;
    of_x = 0; of_y = 0; of_z = 0; focal = 4096;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed at reset values
    push_vertex('0, '0, '0);
    push_vertex(CMAX, CMAX, CMAX);
    push_vertex(CMIN, CMIN, CMIN);
    push_vertex(CMAX, CMIN, 16'sh0001);
    push_vertex(16'sh1000, -16'sh1000, -16'sh1000);  // zero divisor
    push_vertex(16'sh0800, 16'sh0800, -16'sh0fff);   // tiny divisor, saturates
    push_vertex(16'sh0001, -16'sh0001, 16'sh1000);   // rounding ties
    push_vertex(-16'sh0003, 16'sh0003, 16'sh1000);
    drain();

    reg_write(REG_SCALE_X, CMIN);
    reg_write(REG_SCALE_Y, CMAX);
    reg_write(REG_SCALE_Z, -16'sh1000);
    reg_write(REG_OFFSET_X, CMAX);
    reg_write(REG_OFFSET_Y, CMIN);
    reg_write(REG_OFFSET_Z, 16'sh0000);
    reg_write(REG_FOCAL, CMIN);
    push_vertex(CMAX, CMAX, CMAX);
    push_vertex(CMIN, CMIN, CMIN);
    push_vertex('0, '0, 16'sh1000);                  // z' = -1, fault
    push_vertex(16'sh0001, 16'sh0001, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 85;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      reg_write(REG_SCALE_X, (ph == 7) ? CMAX : rand_coord());
      reg_write(REG_SCALE_Y, rand_coord());
      reg_write(REG_SCALE_Z, (ph % 2) ? 16'sh1000 : rand_coord());
      reg_write(REG_OFFSET_X, rand_coord());
      reg_write(REG_OFFSET_Y, rand_coord());
      reg_write(REG_OFFSET_Z, (ph % 2) ? 16'sh0000 : rand_coord());
      reg_write(REG_FOCAL, (ph == 6) ? CMAX : rand_coord());
      for (int n = 0; n < 62; n++) begin
        // with unit z scale and no z offset, -1.0 hits the fault path
        zf = ((ph % 2) && $urandom_range(9) == 0) ? -16'sh1000 : rand_coord();
        push_vertex(rand_coord(), rand_coord(), zf);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
